// ===== rtl/core/llt_pkg.sv =====
// ----------------------------------------------------------------------------
// llt_pkg
// types and constants shared by the lease lock table
// ----------------------------------------------------------------------------
package llt_pkg;

    localparam int ENTITY_W = 32;
    localparam int SITE_W   = 16;
    localparam int TIME_W   = 48;
    localparam int LEN_W    = 32;

    typedef logic [1:0] t_mode;

    localparam t_mode MODE_ACQUIRE = 2'd0;
    localparam t_mode MODE_RELEASE = 2'd1;
    localparam t_mode MODE_LOCKED  = 2'd2;
    localparam t_mode MODE_OWNER   = 2'd3;

    // one stored lease
    typedef struct packed {
        logic                used;
        logic [ENTITY_W-1:0] entity;
        logic [SITE_W-1:0]   owner;
        logic [TIME_W-1:0]   expiry;
    } t_entry;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SCAN,
        ST_EXEC
    } t_state;

endpackage

// ===== rtl/core/lease_lock_table.sv =====
// ----------------------------------------------------------------------------
// lease_lock_table
// lease table with acquire, release, is-locked and owner requests
// ----------------------------------------------------------------------------
// a request runs through ST_SCAN, a sweep of the single read port over every
//   slot, and ST_EXEC, in which the write-back is done; o_done is registered
//   from ST_EXEC; the next start transfer is taken only in ST_IDLE, so a new
//   request is not accepted until the previous one has finished
// reset: synchronous; a clearing pass over every slot empties the memory,
//   busy stays high meanwhile; results cannot be stalled by the receiver
module lease_lock_table
    import llt_pkg::*;
#(
    parameter int TABLE_ENTRIES = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    output logic                busy,
    input  logic [1:0]          i_mode,
    input  logic [ENTITY_W-1:0] i_entity_id,
    input  logic [SITE_W-1:0]   i_site_id,
    input  logic [TIME_W-1:0]   i_now_time,
    input  logic [LEN_W-1:0]    i_lease_length,
    output logic                o_done,
    output logic                o_success,
    output logic                o_locked,
    output logic [SITE_W-1:0]   o_owner,
    output logic                o_owner_valid,
    output logic                o_table_full
);

    localparam int AW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam logic [AW-1:0] LAST = AW'(TABLE_ENTRIES - 1);

    // lease memory, one word per slot
    t_entry mem [TABLE_ENTRIES];

    t_state r_state, n_state;

    // sweep address, shared by the clearing pass and the request scan
    logic [AW-1:0] r_addr;
    logic          r_issue;

    // read side of the memory
    t_entry        r_rd_data;
    logic          r_rd_vld;
    logic [AW-1:0] r_rd_idx;

    // latched request
    t_mode               r_mode;
    logic [ENTITY_W-1:0] r_entity;
    logic [SITE_W-1:0]   r_site;
    logic [TIME_W-1:0]   r_now;
    logic [LEN_W-1:0]    r_len;

    // scan results
    logic                r_found;
    logic [AW-1:0]       r_match_idx;
    logic [SITE_W-1:0]   r_match_owner;
    logic [TIME_W-1:0]   r_match_expiry;
    logic                r_free_found;
    logic [AW-1:0]       r_free_idx;

    // write port controls
    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    t_entry        mem_wdata;

    // request outcome, valid in ST_EXEC
    logic              live;
    logic              same_owner;
    logic [TIME_W:0]   exp_sum;
    logic [TIME_W-1:0] exp_sat;
    logic              res_success;
    logic              res_locked;
    logic [SITE_W-1:0] res_owner;
    logic              res_owner_valid;
    logic              res_full;
    logic              scan_last;

    assign busy      = (r_state != ST_IDLE);
    assign scan_last = r_rd_vld && (r_rd_idx == LAST);

    // lease is live while its expiry lies strictly after now
    assign live       = r_found && (r_match_expiry > r_now);
    assign same_owner = (r_match_owner == r_site);
    assign exp_sum    = {1'b0, r_now} + {{(TIME_W + 1 - LEN_W){1'b0}}, r_len};
    assign exp_sat    = exp_sum[TIME_W] ? {TIME_W{1'b1}} : exp_sum[TIME_W-1:0];

    // memory: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        r_rd_data <= mem[r_addr];
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_CLEAR: if (r_addr == LAST) n_state = ST_IDLE;
            ST_IDLE:  if (start) n_state = ST_SCAN;
            ST_SCAN:  if (scan_last) n_state = ST_EXEC;
            ST_EXEC:  n_state = ST_IDLE;
            default:  n_state = ST_CLEAR;
        endcase
    end

    // outputs of the sequencer: memory write and request outcome
    always_comb begin
        mem_we          = 1'b0;
        mem_waddr       = r_addr;
        mem_wdata       = '0;
        res_success     = 1'b0;
        res_locked      = 1'b0;
        res_owner       = '0;
        res_owner_valid = 1'b0;
        res_full        = 1'b0;
        unique case (r_state)
            ST_CLEAR: begin
                // zero word marks the slot free
                mem_we = 1'b1;
            end
            ST_EXEC: begin
                case (r_mode)
                    MODE_ACQUIRE: begin
                        if (!(live && !same_owner)) begin
                            // reuse the entity's slot, else the lowest free one
                            if (r_found || r_free_found) begin
                                mem_we           = 1'b1;
                                mem_waddr        = r_found ? r_match_idx : r_free_idx;
                                mem_wdata.used   = 1'b1;
                                mem_wdata.entity = r_entity;
                                mem_wdata.owner  = r_site;
                                mem_wdata.expiry = exp_sat;
                                res_success      = 1'b1;
                            end else begin
                                res_full = 1'b1;
                            end
                        end
                    end
                    MODE_RELEASE: begin
                        // only the owner frees, expired or not
                        if (r_found && same_owner) begin
                            mem_we      = 1'b1;
                            mem_waddr   = r_match_idx;
                            res_success = 1'b1;
                        end
                    end
                    MODE_LOCKED: begin
                        res_locked = live;
                    end
                    default: begin
                        if (live) begin
                            res_owner       = r_match_owner;
                            res_owner_valid = 1'b1;
                        end
                    end
                endcase
            end
            default: ;
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_CLEAR;
            r_addr   <= '0;
            r_issue  <= 1'b0;
            r_rd_vld <= 1'b0;
            o_done   <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_rd_vld <= (r_state == ST_SCAN) && r_issue;
            o_done   <= (r_state == ST_EXEC);
            case (r_state)
                ST_CLEAR: begin
                    r_addr <= (r_addr == LAST) ? '0 : r_addr + 1'b1;
                end
                ST_IDLE: begin
                    if (start) begin
                        r_addr  <= '0;
                        r_issue <= 1'b1;
                    end
                end
                ST_SCAN: begin
                    if (r_issue) begin
                        if (r_addr == LAST) begin
                            r_issue <= 1'b0;
                        end else begin
                            r_addr <= r_addr + 1'b1;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    // request latch, scan capture and result registers
    always_ff @(posedge i_clk) begin
        r_rd_idx <= r_addr;
        if (r_state == ST_IDLE && start) begin
            r_mode       <= i_mode;
            r_entity     <= i_entity_id;
            r_site       <= i_site_id;
            r_now        <= i_now_time;
            r_len        <= i_lease_length;
            r_found      <= 1'b0;
            r_free_found <= 1'b0;
        end
        if (r_state == ST_SCAN && r_rd_vld) begin
            // first used slot of the entity
            if (!r_found && r_rd_data.used && r_rd_data.entity == r_entity) begin
                r_found        <= 1'b1;
                r_match_idx    <= r_rd_idx;
                r_match_owner  <= r_rd_data.owner;
                r_match_expiry <= r_rd_data.expiry;
            end
            // lowest free slot
            if (!r_free_found && !r_rd_data.used) begin
                r_free_found <= 1'b1;
                r_free_idx   <= r_rd_idx;
            end
        end
        if (r_state == ST_EXEC) begin
            o_success     <= res_success;
            o_locked      <= res_locked;
            o_owner       <= res_owner;
            o_owner_valid <= res_owner_valid;
            o_table_full  <= res_full;
        end
    end

endmodule
